// File: rtl/segment_volume_clip_core_assert.svh
`ifndef SEGMENT_VOLUME_CLIP_CORE_ASSERT_SVH
`define SEGMENT_VOLUME_CLIP_CORE_ASSERT_SVH

// check a property while reset is low
`define SVC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property at every edge, reset included
`define SVC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/svc_pkg.sv
package svc_pkg;

   localparam int COORD_W   = 32;
   localparam int EXT_W     = 31;
   localparam int SQ_W      = 64;
   localparam int RAD_W     = 2 * SQ_W;
   localparam int CIRC_LAT  = 8;
   localparam int DIV_W     = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic SHAPE_CYL = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_X = 3'd0,
      CSR_START_Y = 3'd1,
      CSR_START_Z = 3'd2,
      CSR_END_X   = 3'd3,
      CSR_END_Y   = 3'd4,
      CSR_END_Z   = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] start_z;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] end_z;
   } cfg_type;

   typedef struct packed {
      logic                      shape;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic        [EXT_W-1:0]   half_x;
      logic        [EXT_W-1:0]   half_y;
      logic        [EXT_W-1:0]   half_z;
      logic        [EXT_W-1:0]   radius;
      logic signed [COORD_W-1:0] z_low;
      logic signed [COORD_W-1:0] z_high;
   } item_type;

   typedef struct packed {
      logic signed [61:0] md;
      logic        [60:0] a2;
      logic               a2_zero;
      logic               vert_ok;
      logic               k_pos;
   } circ_type;

endpackage

// File: rtl/svc_delay.sv
module svc_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] in_data,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign out_data = tap_ff[DEPTH-1];

endmodule

// File: rtl/svc_circle.sv
module svc_circle (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  svc_pkg::cfg_type           cfg,
   input  svc_pkg::item_type          item,
   output logic                       out_valid,
   output svc_pkg::circ_type          circ,
   output logic [svc_pkg::RAD_W-1:0]  radicand
);
   import svc_pkg::*;

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      logic signed [32:0] n;
      n = -v;
      return v[32] ? n : v;
   endfunction

   function automatic logic signed [30:0] scale(input logic signed [32:0] v,
                                                input logic [1:0] sh);
      logic        [32:0] m;
      logic signed [30:0] p;
      m = mag33(v) >> sh;
      p = {1'b0, m[29:0]};
      return v[32] ? -p : p;
   endfunction

   logic [CIRC_LAT-1:0] vld_ff;

   logic signed [32:0] dx1_ff, dy1_ff, mx1_ff, my1_ff;
   logic signed [32:0] dx1_in, dy1_in, mx1_in, my1_in;
   logic [EXT_W-1:0]   rad1_ff;

   logic [32:0]        dx1_mag, dy1_mag, mx1_mag, my1_mag;
   logic [2:0]         hi_bits;
   logic [1:0]         sh;
   logic signed [30:0] dx2_ff, dy2_ff, mx2_ff, my2_ff;
   logic [29:0]        rad2_ff;
   logic [EXT_W-1:0]   rad_sh;

   logic signed [61:0] pdxdx_ff, pdydy_ff, pmxdy_ff, pmydx_ff;
   logic signed [61:0] pmxdx_ff, pmydy_ff, pmxmx_ff, pmymy_ff;
   logic        [59:0] prr_ff;

   logic [60:0]        a2_4_ff, mm_4_ff;
   logic signed [61:0] cr_4_ff, md_4_ff;
   logic [59:0]        r2_4_ff;

   logic signed [61:0] crn;
   logic [60:0]        a2_5_ff, crm_5_ff;
   logic [59:0]        r2_5_ff;
   logic signed [61:0] md_5_ff;
   logic               a2z_5_ff, vok_5_ff;

   logic [63:0]        pll_ff, plh_ff, phl_ff, phh_ff, qll_ff, qlh_ff, qhh_ff;
   logic signed [61:0] md_6_ff;
   logic [60:0]        a2_6_ff;
   logic               a2z_6_ff, vok_6_ff;

   logic [RAD_W-1:0]   p_7_ff, q_7_ff;
   logic signed [61:0] md_7_ff;
   logic [60:0]        a2_7_ff;
   logic               a2z_7_ff, vok_7_ff;

   logic [RAD_W-1:0]   k_8_ff;
   logic               kpos_8_ff;
   logic signed [61:0] md_8_ff;
   logic [60:0]        a2_8_ff;
   logic               a2z_8_ff, vok_8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[CIRC_LAT-2:0], in_valid};
      end
   end

   always_comb begin
      dx1_in = {cfg.end_x[31], cfg.end_x} - {cfg.start_x[31], cfg.start_x};
      dy1_in = {cfg.end_y[31], cfg.end_y} - {cfg.start_y[31], cfg.start_y};
      mx1_in = {cfg.start_x[31], cfg.start_x} - {item.center_x[31], item.center_x};
      my1_in = {cfg.start_y[31], cfg.start_y} - {item.center_y[31], item.center_y};
   end

   always_comb begin
      dx1_mag = mag33(dx1_ff);
      dy1_mag = mag33(dy1_ff);
      mx1_mag = mag33(mx1_ff);
      my1_mag = mag33(my1_ff);
      hi_bits = dx1_mag[32:30] | dy1_mag[32:30] |
                mx1_mag[32:30] | my1_mag[32:30] | {2'b00, rad1_ff[30]};
      if (hi_bits[2]) begin
         sh = 2'd3;
      end else if (hi_bits[1]) begin
         sh = 2'd2;
      end else if (hi_bits[0]) begin
         sh = 2'd1;
      end else begin
         sh = 2'd0;
      end
      rad_sh = rad1_ff >> sh;
      crn    = -cr_4_ff;
   end

   always_ff @(posedge clock) begin
      dx1_ff  <= dx1_in;
      dy1_ff  <= dy1_in;
      mx1_ff  <= mx1_in;
      my1_ff  <= my1_in;
      rad1_ff <= item.radius;

      dx2_ff  <= scale(dx1_ff, sh);
      dy2_ff  <= scale(dy1_ff, sh);
      mx2_ff  <= scale(mx1_ff, sh);
      my2_ff  <= scale(my1_ff, sh);
      rad2_ff <= rad_sh[29:0];

      pdxdx_ff <= dx2_ff * dx2_ff;
      pdydy_ff <= dy2_ff * dy2_ff;
      pmxdy_ff <= mx2_ff * dy2_ff;
      pmydx_ff <= my2_ff * dx2_ff;
      pmxdx_ff <= mx2_ff * dx2_ff;
      pmydy_ff <= my2_ff * dy2_ff;
      pmxmx_ff <= mx2_ff * mx2_ff;
      pmymy_ff <= my2_ff * my2_ff;
      prr_ff   <= rad2_ff * rad2_ff;

      a2_4_ff <= {1'b0, pdxdx_ff[59:0]} + {1'b0, pdydy_ff[59:0]};
      mm_4_ff <= {1'b0, pmxmx_ff[59:0]} + {1'b0, pmymy_ff[59:0]};
      cr_4_ff <= pmxdy_ff - pmydx_ff;
      md_4_ff <= pmxdx_ff + pmydy_ff;
      r2_4_ff <= prr_ff;

      a2_5_ff  <= a2_4_ff;
      r2_5_ff  <= r2_4_ff;
      md_5_ff  <= md_4_ff;
      crm_5_ff <= cr_4_ff[61] ? crn[60:0] : cr_4_ff[60:0];
      a2z_5_ff <= (a2_4_ff == '0);
      vok_5_ff <= (mm_4_ff <= {1'b0, r2_4_ff});

      pll_ff   <= a2_5_ff[31:0] * r2_5_ff[31:0];
      plh_ff   <= a2_5_ff[31:0] * r2_5_ff[59:32];
      phl_ff   <= a2_5_ff[60:32] * r2_5_ff[31:0];
      phh_ff   <= a2_5_ff[60:32] * r2_5_ff[59:32];
      qll_ff   <= crm_5_ff[31:0] * crm_5_ff[31:0];
      qlh_ff   <= crm_5_ff[31:0] * crm_5_ff[60:32];
      qhh_ff   <= crm_5_ff[60:32] * crm_5_ff[60:32];
      md_6_ff  <= md_5_ff;
      a2_6_ff  <= a2_5_ff;
      a2z_6_ff <= a2z_5_ff;
      vok_6_ff <= vok_5_ff;

      p_7_ff   <= RAD_W'(pll_ff) + (RAD_W'(plh_ff) << 32) + (RAD_W'(phl_ff) << 32) +
                  (RAD_W'(phh_ff) << 64);
      q_7_ff   <= RAD_W'(qll_ff) + (RAD_W'(qlh_ff) << 33) + (RAD_W'(qhh_ff) << 64);
      md_7_ff  <= md_6_ff;
      a2_7_ff  <= a2_6_ff;
      a2z_7_ff <= a2z_6_ff;
      vok_7_ff <= vok_6_ff;

      k_8_ff    <= p_7_ff - q_7_ff;
      kpos_8_ff <= (p_7_ff > q_7_ff);
      md_8_ff   <= md_7_ff;
      a2_8_ff   <= a2_7_ff;
      a2z_8_ff  <= a2z_7_ff;
      vok_8_ff  <= vok_7_ff;
   end

   assign out_valid    = vld_ff[CIRC_LAT-1];
   assign radicand     = k_8_ff;
   assign circ.md      = md_8_ff;
   assign circ.a2      = a2_8_ff;
   assign circ.a2_zero = a2z_8_ff;
   assign circ.vert_ok = vok_8_ff;
   assign circ.k_pos   = kpos_8_ff;

endmodule

// File: rtl/svc_isqrt.sv
module svc_isqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [svc_pkg::RAD_W-1:0] radicand,
   output logic                      out_valid,
   output logic [svc_pkg::SQ_W-1:0]  root
);
   import svc_pkg::*;

   localparam int REM_W = SQ_W + 3;

   logic [SQ_W-1:0]  vld_ff;
   logic [SQ_W-1:0]  root_ff [SQ_W];
   logic [REM_W-1:0] rem_ff  [SQ_W-1];
   logic [RAD_W-1:0] x_ff    [SQ_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[SQ_W-2:0], in_valid};
      end
   end

   for (genvar g = 0; g < SQ_W; g++) begin : g_step
      logic [REM_W-1:0] rem_prev, rem_sh, trial;
      logic [SQ_W-1:0]  root_prev;
      logic [RAD_W-1:0] x_prev;
      logic             ge;

      if (g == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign x_prev    = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[g-1];
         assign root_prev = root_ff[g-1];
         assign x_prev    = x_ff[g-1];
      end

      always_comb begin
         rem_sh = {rem_prev[REM_W-3:0], x_prev[RAD_W-1 -: 2]};
         trial  = {1'b0, root_prev, 2'b01};
         ge     = (rem_sh >= trial);
      end

      always_ff @(posedge clock) begin
         root_ff[g] <= {root_prev[SQ_W-2:0], ge};
      end

      if (g < SQ_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[g] <= ge ? rem_sh - trial : rem_sh;
            x_ff[g]   <= {x_prev[RAD_W-3:0], 2'b00};
         end
      end
   end

   assign out_valid = vld_ff[SQ_W-1];
   assign root      = root_ff[SQ_W-1];

endmodule

// File: rtl/svc_frac_div.sv
module svc_frac_div #(
   parameter int T_FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic signed [svc_pkg::DIV_W-1:0] num,
   input  logic signed [svc_pkg::DIV_W-1:0] den,
   output logic                             out_valid,
   output logic [T_FRAC_BITS:0]             frac
);
   import svc_pkg::*;

   localparam int TB = T_FRAC_BITS;

   logic                    vld0_ff;
   logic signed [DIV_W-1:0] n0_ff, d0_ff;
   logic [TB-1:0]           vld_ff;
   logic [DIV_W-1:0]        rem_ff [TB-1];
   logic [DIV_W-1:0]        d_ff   [TB-1];
   logic [TB-1:0]           q_ff   [TB];
   logic                    zero_ff [TB];
   logic                    one_ff  [TB];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld_ff  <= '0;
      end else begin
         vld0_ff <= in_valid;
         vld_ff  <= {vld_ff[TB-2:0], vld0_ff};
      end
   end

   always_ff @(posedge clock) begin
      n0_ff <= den[DIV_W-1] ? -num : num;
      d0_ff <= den[DIV_W-1] ? -den : den;
   end

   for (genvar g = 0; g < TB; g++) begin : g_step
      logic [DIV_W-1:0] rem_prev, d_prev, rem_sh;
      logic [TB-1:0]    q_prev;
      logic             zero_prev, one_prev, ge;

      if (g == 0) begin : g_first
         assign rem_prev  = n0_ff;
         assign d_prev    = d0_ff;
         assign q_prev    = '0;
         assign zero_prev = (n0_ff <= 0);
         assign one_prev  = (n0_ff >= d0_ff);
      end else begin : g_next
         assign rem_prev  = rem_ff[g-1];
         assign d_prev    = d_ff[g-1];
         assign q_prev    = q_ff[g-1];
         assign zero_prev = zero_ff[g-1];
         assign one_prev  = one_ff[g-1];
      end

      always_comb begin
         rem_sh = {rem_prev[DIV_W-2:0], 1'b0};
         ge     = (rem_sh >= d_prev);
      end

      always_ff @(posedge clock) begin
         q_ff[g]    <= {q_prev[TB-2:0], ge};
         zero_ff[g] <= zero_prev;
         one_ff[g]  <= one_prev;
      end

      if (g < TB - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[g] <= ge ? rem_sh - d_prev : rem_sh;
            d_ff[g]   <= d_prev;
         end
      end
   end

   always_comb begin
      if (zero_ff[TB-1]) begin
         frac = '0;
      end else if (one_ff[TB-1]) begin
         frac = {1'b1, {TB{1'b0}}};
      end else begin
         frac = {1'b0, q_ff[TB-1]};
      end
   end

   assign out_valid = vld_ff[TB-1];

endmodule

// File: rtl/segment_volume_clip_core.sv
// Clips the configured segment start..end against one box or vertical cylinder per request
// and returns hit with the entry and exit fractions (zero on a miss). A request is taken in
// any cycle with start high; busy never rises, so a new request may follow every cycle.
// Each request gives exactly one result, in request order, after it has passed the 64-step
// square-root pipeline of the circle test and the T_FRAC_BITS-step fraction dividers
// behind it. rsp_valid marks a result for one cycle only and cannot be held off, so
// capture it when it appears. Write the segment registers only when no request is in
// flight.
module segment_volume_clip_core #(
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_shape,
   input  logic signed [svc_pkg::COORD_W-1:0]   req_center_x,
   input  logic signed [svc_pkg::COORD_W-1:0]   req_center_y,
   input  logic signed [svc_pkg::COORD_W-1:0]   req_center_z,
   input  logic        [svc_pkg::EXT_W-1:0]     req_half_x,
   input  logic        [svc_pkg::EXT_W-1:0]     req_half_y,
   input  logic        [svc_pkg::EXT_W-1:0]     req_half_z,
   input  logic        [svc_pkg::EXT_W-1:0]     req_radius,
   input  logic signed [svc_pkg::COORD_W-1:0]   req_z_low,
   input  logic signed [svc_pkg::COORD_W-1:0]   req_z_high,
   input  logic                                 csr_we,
   input  logic        [svc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [svc_pkg::COORD_W-1:0]   csr_wdata,
   output logic                                 rsp_valid,
   output logic                                 rsp_hit,
   output logic        [T_FRAC_BITS:0]          rsp_t_enter,
   output logic        [T_FRAC_BITS:0]          rsp_t_exit
);
   import svc_pkg::*;

   localparam int TW      = T_FRAC_BITS + 1;
   localparam int LANES   = 6;
   localparam int DIV_LAT = T_FRAC_BITS + 1;
   localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

   typedef struct packed {
      logic       shape;
      logic [2:0] par;
      logic [2:0] pok;
      logic       a2z;
      logic       vok;
      logic       kpos;
   } flag_type;

   function automatic logic [TW-1:0] fmax(input logic [TW-1:0] a, input logic [TW-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [TW-1:0] fmin(input logic [TW-1:0] a, input logic [TW-1:0] b);
      return (a < b) ? a : b;
   endfunction

   cfg_type  cfg_ff, cfg_in;
   item_type item_ff, item_d;
   logic     s1_valid_ff;
   logic     accept;

   logic                c_valid, s_valid;
   circ_type            circ_c, circ_d;
   logic [RAD_W-1:0]    radicand;
   logic [SQ_W-1:0]     sq_root;
   logic [$bits(item_type)-1:0] item_raw;
   logic [$bits(circ_type)-1:0] circ_raw;

   logic signed [32:0]  dx_e, dy_e, dz_e;
   logic signed [33:0]  bx_lo, bx_hi, by_lo, by_hi, z_lo, z_hi;
   logic signed [63:0]  md_e, s_e;
   logic signed [DIV_W-1:0] num_e [LANES];
   logic signed [DIV_W-1:0] den_e [LANES];
   flag_type            flag_e;

   logic                    e_valid_ff;
   logic signed [DIV_W-1:0] num_ff [LANES];
   logic signed [DIV_W-1:0] den_ff [LANES];
   flag_type                flag_ff, flag_d;
   logic [$bits(flag_type)-1:0] flag_raw;

   logic [LANES-1:0]    div_valid;
   logic [TW-1:0]       frac [LANES];

   logic [TW-1:0]       lim_lo [3];
   logic [TW-1:0]       lim_hi [3];
   logic [2:0]          lim_ok;
   logic [TW-1:0]       c_lo, c_hi, lo, hi;
   logic                c_ok, ok, hit;

   logic                rsp_valid_ff, hit_ff;
   logic [TW-1:0]       enter_ff, exit_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_START_X: cfg_in.start_x = csr_wdata;
            CSR_START_Y: cfg_in.start_y = csr_wdata;
            CSR_START_Z: cfg_in.start_z = csr_wdata;
            CSR_END_X:   cfg_in.end_x   = csr_wdata;
            CSR_END_Y:   cfg_in.end_y   = csr_wdata;
            CSR_END_Z:   cfg_in.end_z   = csr_wdata;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.shape    <= req_shape;
         item_ff.center_x <= req_center_x;
         item_ff.center_y <= req_center_y;
         item_ff.center_z <= req_center_z;
         item_ff.half_x   <= req_half_x;
         item_ff.half_y   <= req_half_y;
         item_ff.half_z   <= req_half_z;
         item_ff.radius   <= req_radius;
         item_ff.z_low    <= req_z_low;
         item_ff.z_high   <= req_z_high;
      end
   end

   svc_circle u_circle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .cfg       (cfg_ff),
      .item      (item_ff),
      .out_valid (c_valid),
      .circ      (circ_c),
      .radicand  (radicand)
   );

   svc_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .radicand  (radicand),
      .out_valid (s_valid),
      .root      (sq_root)
   );

   svc_delay #(
      .WIDTH ($bits(item_type)),
      .DEPTH (CIRC_LAT + SQ_W)
   ) u_item_delay (
      .clock    (clock),
      .in_data  (item_ff),
      .out_data (item_raw)
   );

   svc_delay #(
      .WIDTH ($bits(circ_type)),
      .DEPTH (SQ_W)
   ) u_circ_delay (
      .clock    (clock),
      .in_data  (circ_c),
      .out_data (circ_raw)
   );

   assign item_d = item_type'(item_raw);
   assign circ_d = circ_type'(circ_raw);

   always_comb begin
      dx_e = {cfg_ff.end_x[31], cfg_ff.end_x} - {cfg_ff.start_x[31], cfg_ff.start_x};
      dy_e = {cfg_ff.end_y[31], cfg_ff.end_y} - {cfg_ff.start_y[31], cfg_ff.start_y};
      dz_e = {cfg_ff.end_z[31], cfg_ff.end_z} - {cfg_ff.start_z[31], cfg_ff.start_z};

      bx_lo = {{2{item_d.center_x[31]}}, item_d.center_x} - {3'b000, item_d.half_x}
              - {{2{cfg_ff.start_x[31]}}, cfg_ff.start_x};
      bx_hi = {{2{item_d.center_x[31]}}, item_d.center_x} + {3'b000, item_d.half_x}
              - {{2{cfg_ff.start_x[31]}}, cfg_ff.start_x};
      by_lo = {{2{item_d.center_y[31]}}, item_d.center_y} - {3'b000, item_d.half_y}
              - {{2{cfg_ff.start_y[31]}}, cfg_ff.start_y};
      by_hi = {{2{item_d.center_y[31]}}, item_d.center_y} + {3'b000, item_d.half_y}
              - {{2{cfg_ff.start_y[31]}}, cfg_ff.start_y};
      if (item_d.shape == SHAPE_CYL) begin
         z_lo = {{2{item_d.z_low[31]}}, item_d.z_low}
                - {{2{cfg_ff.start_z[31]}}, cfg_ff.start_z};
         z_hi = {{2{item_d.z_high[31]}}, item_d.z_high}
                - {{2{cfg_ff.start_z[31]}}, cfg_ff.start_z};
      end else begin
         z_lo = {{2{item_d.center_z[31]}}, item_d.center_z} - {3'b000, item_d.half_z}
                - {{2{cfg_ff.start_z[31]}}, cfg_ff.start_z};
         z_hi = {{2{item_d.center_z[31]}}, item_d.center_z} + {3'b000, item_d.half_z}
                - {{2{cfg_ff.start_z[31]}}, cfg_ff.start_z};
      end

      md_e = {{2{circ_d.md[61]}}, circ_d.md};
      s_e  = $signed(sq_root);

      if (item_d.shape == SHAPE_CYL) begin
         num_e[0] = -md_e - s_e;
         num_e[1] = -md_e + s_e;
         den_e[0] = {3'b000, circ_d.a2};
         den_e[1] = {3'b000, circ_d.a2};
      end else begin
         num_e[0] = DIV_W'(bx_lo);
         num_e[1] = DIV_W'(bx_hi);
         den_e[0] = DIV_W'(dx_e);
         den_e[1] = DIV_W'(dx_e);
      end
      num_e[2] = DIV_W'(by_lo);
      num_e[3] = DIV_W'(by_hi);
      den_e[2] = DIV_W'(dy_e);
      den_e[3] = DIV_W'(dy_e);
      num_e[4] = DIV_W'(z_lo);
      num_e[5] = DIV_W'(z_hi);
      den_e[4] = DIV_W'(dz_e);
      den_e[5] = DIV_W'(dz_e);

      flag_e.shape = item_d.shape;
      flag_e.par   = {(dz_e == 0), (dy_e == 0), (dx_e == 0)};
      flag_e.pok   = {(z_lo <= 0) && (z_hi >= 0), (by_lo <= 0) && (by_hi >= 0),
                      (bx_lo <= 0) && (bx_hi >= 0)};
      flag_e.a2z   = circ_d.a2_zero;
      flag_e.vok   = circ_d.vert_ok;
      flag_e.kpos  = circ_d.k_pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= s_valid;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_e;
      den_ff  <= den_e;
      flag_ff <= flag_e;
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      svc_frac_div #(
         .T_FRAC_BITS (T_FRAC_BITS)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (e_valid_ff),
         .num       (num_ff[g]),
         .den       (den_ff[g]),
         .out_valid (div_valid[g]),
         .frac      (frac[g])
      );
   end

   svc_delay #(
      .WIDTH ($bits(flag_type)),
      .DEPTH (DIV_LAT)
   ) u_flag_delay (
      .clock    (clock),
      .in_data  (flag_ff),
      .out_data (flag_raw)
   );

   assign flag_d = flag_type'(flag_raw);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (flag_d.par[k]) begin
            lim_lo[k] = '0;
            lim_hi[k] = T_ONE;
            lim_ok[k] = flag_d.pok[k];
         end else begin
            lim_lo[k] = fmin(frac[2*k], frac[2*k+1]);
            lim_hi[k] = fmax(frac[2*k], frac[2*k+1]);
            lim_ok[k] = 1'b1;
         end
      end

      if (flag_d.a2z) begin
         c_lo = '0;
         c_hi = T_ONE;
         c_ok = flag_d.vok;
      end else begin
         c_lo = frac[0];
         c_hi = frac[1];
         c_ok = flag_d.kpos;
      end

      if (flag_d.shape == SHAPE_CYL) begin
         lo = fmax(c_lo, lim_lo[2]);
         hi = fmin(c_hi, lim_hi[2]);
         ok = c_ok && lim_ok[2];
      end else begin
         lo = fmax(fmax(lim_lo[0], lim_lo[1]), lim_lo[2]);
         hi = fmin(fmin(lim_hi[0], lim_hi[1]), lim_hi[2]);
         ok = &lim_ok;
      end
      hit = ok && (hi > lo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= &div_valid;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff   <= hit;
      enter_ff <= hit ? lo : '0;
      exit_ff  <= hit ? hi : '0;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = hit_ff;
   assign rsp_t_enter = enter_ff;
   assign rsp_t_exit  = exit_ff;

endmodule

// File: rtl/svc_checker.sv
`include "segment_volume_clip_core_assert.svh"

module svc_checker #(
   parameter int T_FRAC_BITS = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic                 rsp_hit,
   input logic [T_FRAC_BITS:0] rsp_t_enter,
   input logic [T_FRAC_BITS:0] rsp_t_exit
);
   import svc_pkg::*;

   localparam int LAT = CIRC_LAT + SQ_W + T_FRAC_BITS + 4;
   localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

   `SVC_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "response after reset")
   `SVC_ASSERT(a_miss_zero, clock, reset, rsp_valid && !rsp_hit |-> rsp_t_enter == '0 && rsp_t_exit == '0, "miss with nonzero fractions")
   `SVC_ASSERT(a_hit_order, clock, reset, rsp_valid && rsp_hit |-> rsp_t_exit > rsp_t_enter && rsp_t_exit <= T_ONE, "hit interval malformed")
   `SVC_ASSERT(a_rsp_origin, clock, reset, rsp_valid |-> $past(start && !busy, LAT), "response without request")

endmodule

bind segment_volume_clip_core svc_checker #(.T_FRAC_BITS(T_FRAC_BITS)) u_svc_checker (.*);
